FILE: hw/rtl/rda_pkg.sv
// ----------------------------------------------------------------------------
// rda_pkg
// Shared types, constants and the half-step decoding table of the rotary
// encoder decoder.
// ----------------------------------------------------------------------------
package rda_pkg;

  // width of the millisecond timestamp arithmetic
  localparam int TIME_BITS = 32;
  localparam int SENS_BITS = 8;
  localparam int ACC_BITS  = 32;
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  // reset values of the configuration registers
  localparam logic [SENS_BITS-1:0] SENS_RESET   = 8'd16;
  localparam logic                 SWITCH_RESET = 1'b1;

  // decoder start state (mid position)
  localparam logic [2:0] DEC_START = 3'd3;

  // register indexes, taken from paddr[2]
  localparam logic REG_SENS   = 1'b0;
  localparam logic REG_SWITCH = 1'b1;

  // input command codes
  localparam logic CMD_PIN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // detent direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  typedef struct packed {
    logic                 cmd;
    logic                 left_level;
    logic                 right_level;
    logic                 switch_level;
    logic [TIME_BITS-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] step_total;
    logic                       pressed;
    logic [1:0]                 step_dir;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SQ,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] next;
    logic       cw;
    logic       ccw;
  } dec_t;

  // half-step table; act = {left active, right active}
  function automatic dec_t decode_next(input logic [2:0] cur, input logic [1:0] act);
    dec_t d;
    d = '{next: 3'd0, cw: 1'b0, ccw: 1'b0};
    unique case (cur)
      3'd1: begin
        unique case (act)
          2'd0: begin d.next = 3'd3; d.ccw = 1'b1; end
          2'd1: d.next = 3'd0;
          2'd2: d.next = 3'd1;
          default: d.next = 3'd0;
        endcase
      end
      3'd2: begin
        unique case (act)
          2'd0: begin d.next = 3'd3; d.cw = 1'b1; end
          2'd1: d.next = 3'd2;
          2'd2: d.next = 3'd0;
          default: d.next = 3'd0;
        endcase
      end
      3'd3: begin
        unique case (act)
          2'd0: d.next = 3'd3;
          2'd1: d.next = 3'd5;
          2'd2: d.next = 3'd4;
          default: d.next = 3'd0;
        endcase
      end
      3'd4: begin
        unique case (act)
          2'd0: d.next = 3'd3;
          2'd1: d.next = 3'd3;
          2'd2: d.next = 3'd4;
          default: d.next = 3'd0;
        endcase
      end
      3'd5: begin
        unique case (act)
          2'd0: d.next = 3'd3;
          2'd1: d.next = 3'd5;
          2'd2: d.next = 3'd3;
          default: d.next = 3'd0;
        endcase
      end
      // state 0 and the unused codes 6 and 7
      default: begin
        unique case (act)
          2'd0: d.next = 3'd3;
          2'd1: d.next = 3'd2;
          2'd2: d.next = 3'd1;
          default: d.next = 3'd0;
        endcase
      end
    endcase
    return d;
  endfunction

endpackage

FILE: hw/rtl/rotary_decoder_with_acceleration.sv
// ----------------------------------------------------------------------------
// rotary_decoder_with_acceleration
// Half-step quadrature decoder with speed-dependent acceleration of a
// saturating signed step total, read and cleared by command.
// ----------------------------------------------------------------------------
// Each item is either a pin event or a read command and gives exactly one
// result item. A read, or a pin event that completes no detent, goes from
// acceptance through the DONE state into the output register. A pin
// event that completes a detent passes the DIV, SQ, ACC and DONE states:
// the speed factor (sensitivity / elapsed) is found by a restoring divider
// that retires one quotient bit per cycle, then it is squared and added to
// the total with saturation in the next cycle. The next item is accepted
// as soon as the result has moved to the output register, even while that
// register still waits to be taken. A configuration write applies to the
// items accepted after it; a detent already being worked on keeps the
// settings it was accepted with.
module rotary_decoder_with_acceleration
  import rda_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  state_t state, state_next;

  // configuration registers
  logic [SENS_BITS-1:0] sensitivity_ms;
  logic                 has_switch;

  // decoder state
  logic [2:0]                 decode_state;
  logic [TIME_BITS-1:0]       last_detent_time;
  logic signed [ACC_BITS-1:0] step_accum;
  logic                       switch_pressed;

  // pending result
  logic signed [ACC_BITS-1:0] res_total;
  logic [1:0]                 res_dir;

  // divider and square
  logic [SENS_BITS-1:0]   div_quo;
  logic [SENS_BITS:0]     div_rem;
  logic [SENS_BITS-1:0]   div_den;
  logic [2:0]             div_cnt;
  logic [2*SENS_BITS-1:0] speed;

  // control decoded from the state
  logic in_accept;
  logic load_out;

  // combinational helpers
  dec_t                 dec;
  logic                 sw_pressed_new;
  logic [SENS_BITS-1:0] sens_eff;
  logic [TIME_BITS-1:0] diff;
  logic [SENS_BITS-1:0] elapsed;
  logic [SENS_BITS:0]   trial;
  logic [SENS_BITS:0]   trial_sub;
  logic                 trial_ok;
  logic signed [ACC_BITS+1:0] acc_ext;
  logic signed [ACC_BITS+1:0] sum;
  logic signed [ACC_BITS-1:0] sat_sum;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity_ms <= SENS_RESET;
      has_switch     <= SWITCH_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SENS:   sensitivity_ms <= pwdata[SENS_BITS-1:0];
        REG_SWITCH: has_switch     <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_SENS:   prdata[SENS_BITS-1:0] = sensitivity_ms;
      REG_SWITCH: prdata[0]             = has_switch;
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == CMD_PIN && (dec.cw || dec.ccw)) begin
            state_next = S_DIV;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (div_cnt == 3'd7) begin
          state_next = S_SQ;
        end
      end
      S_SQ:   state_next = S_ACC;
      S_ACC:  state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    load_out  = (state == S_DONE) && (!out_valid || !out_stall);
  end

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // pin event decoding and elapsed time clamp
  // ---------------------------------------------------------------------------
  always_comb begin
    dec            = decode_next(decode_state, {~in_data.left_level, ~in_data.right_level});
    sw_pressed_new = has_switch ? ~in_data.switch_level : switch_pressed;
    sens_eff       = (sensitivity_ms == '0) ? SENS_BITS'(1) : sensitivity_ms;
    diff           = in_data.now_ms - last_detent_time;
    if (diff == '0) begin
      elapsed = SENS_BITS'(1);
    end else if (diff > TIME_BITS'(sens_eff)) begin
      elapsed = sens_eff;
    end else begin
      elapsed = diff[SENS_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // restoring divider step, one quotient bit a cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    trial     = {div_rem[SENS_BITS-1:0], div_quo[SENS_BITS-1]};
    trial_sub = trial - {1'b0, div_den};
    trial_ok  = (trial >= {1'b0, div_den});
  end

  // ---------------------------------------------------------------------------
  // saturating accumulate
  // ---------------------------------------------------------------------------
  always_comb begin
    acc_ext = {{2{step_accum[ACC_BITS-1]}}, step_accum};
    if (res_dir == DIR_CW) begin
      sum = acc_ext + $signed({{(ACC_BITS+2-2*SENS_BITS){1'b0}}, speed});
    end else begin
      sum = acc_ext - $signed({{(ACC_BITS+2-2*SENS_BITS){1'b0}}, speed});
    end
    if (sum[ACC_BITS+1:ACC_BITS-1] == 3'b000 || sum[ACC_BITS+1:ACC_BITS-1] == 3'b111) begin
      sat_sum = sum[ACC_BITS-1:0];
    end else if (sum[ACC_BITS+1]) begin
      sat_sum = {1'b1, {(ACC_BITS-1){1'b0}}};
    end else begin
      sat_sum = {1'b0, {(ACC_BITS-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_state     <= DEC_START;
      last_detent_time <= '0;
      step_accum       <= '0;
      switch_pressed   <= 1'b0;
    end else begin
      if (in_accept) begin
        if (in_data.cmd == CMD_READ) begin
          res_total  <= step_accum;
          res_dir    <= DIR_NONE;
          step_accum <= '0;
        end else begin
          switch_pressed <= sw_pressed_new;
          decode_state   <= dec.next;
          res_total      <= step_accum;
          if (dec.cw || dec.ccw) begin
            last_detent_time <= in_data.now_ms;
            res_dir          <= dec.cw ? DIR_CW : DIR_CCW;
            div_quo          <= sens_eff;
            div_den          <= elapsed;
            div_rem          <= '0;
            div_cnt          <= '0;
          end else begin
            res_dir <= DIR_NONE;
          end
        end
      end
      // one quotient bit shifted in per cycle
      if (state == S_DIV) begin
        div_quo <= {div_quo[SENS_BITS-2:0], trial_ok};
        div_rem <= trial_ok ? trial_sub : trial;
        div_cnt <= div_cnt + 3'd1;
      end
      if (state == S_SQ) begin
        speed <= div_quo * div_quo;
      end
      if (state == S_ACC) begin
        step_accum <= sat_sum;
        res_total  <= sat_sum;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.step_total <= res_total;
      out_data.pressed    <= switch_pressed;
      out_data.step_dir   <= res_dir;
    end
  end

endmodule

FILE: hw/rtl/rda_checker.sv
// ----------------------------------------------------------------------------
// rda_checker
// Port-level assertions for the rotary encoder decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rda_checker
  import rda_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed or dropped");

  // no result item straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item valid after reset");

  // the block is busy in the cycle after it takes an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted on consecutive cycles");

  // direction code is never the unused value
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.step_dir == DIR_NONE || out_data.step_dir == DIR_CW ||
                   out_data.step_dir == DIR_CCW))
    else $error("illegal step direction code");

endmodule

bind rotary_decoder_with_acceleration rda_checker u_rda_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rotary encoder decoder. Pin events and reads
// are queued per phase, driven with random gaps and random result stalls,
// and every result is checked against a built-in prediction of the
// half-step table, the accelerated step count and the saturating total.
// ----------------------------------------------------------------------------
module tb_top;
  import rda_pkg::*;

  localparam int     IDLE_LIMIT   = 2000;
  localparam int     SPIN_DETENTS = 8;
  localparam longint TOTAL_MAX    = 64'sd2147483647;
  localparam longint TOTAL_MIN    = -64'sd2147483648;

  // active pin pairs, {left, right}
  localparam logic [1:0] ACT_NONE  = 2'b00;
  localparam logic [1:0] ACT_RIGHT = 2'b01;
  localparam logic [1:0] ACT_LEFT  = 2'b10;
  localparam logic [1:0] ACT_BOTH  = 2'b11;

  // direction flags above the next state in a table entry
  localparam logic [4:0] TURN_CCW = 5'b10000;
  localparam logic [4:0] TURN_CW  = 5'b01000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [ADDR_BITS-1:0] paddr     = '0;
  logic [DATA_BITS-1:0] pwdata    = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // predicted encoder state and settings
  logic [SENS_BITS-1:0]       cfg_sens    = SENS_RESET;
  logic                       cfg_switch  = SWITCH_RESET;
  logic [2:0]                 enc_state   = DEC_START;
  logic [TIME_BITS-1:0]       enc_last_ms = '0;
  logic signed [ACC_BITS-1:0] enc_total   = '0;
  logic                       enc_pressed = 1'b0;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  out_item_t want;

  int items_queued = 0;
  int pin_events   = 0;
  int read_cmds    = 0;
  int cw_detents   = 0;
  int ccw_detents  = 0;
  int clamped      = 0;
  int settings     = 0;
  int mismatches   = 0;
  int gap_run      = 0;
  int stall_run    = 0;
  int idle_cycles  = 0;
  bit calm         = 1'b0;

  logic [TIME_BITS-1:0] gen_ms = '0;
  logic                 gen_sw = 1'b1;

  rotary_decoder_with_acceleration u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // half-step table, entries packed {act 3, act 2, act 1, act 0}
  function automatic logic [4:0] half_step(input logic [2:0] cur, input logic [1:0] act);
    logic [19:0] row;
    case (cur)
      3'd1: row = {5'd0, 5'd1, 5'd0, TURN_CCW | 5'd3};
      3'd2: row = {5'd0, 5'd0, 5'd2, TURN_CW | 5'd3};
      3'd3: row = {5'd0, 5'd4, 5'd5, 5'd3};
      3'd4: row = {5'd0, 5'd4, 5'd3, 5'd3};
      3'd5: row = {5'd0, 5'd3, 5'd5, 5'd3};
      // state 0, and the unused codes fall back to it
      default: row = {5'd0, 5'd1, 5'd2, 5'd3};
    endcase
    return row[int'(act) * 5 +: 5];
  endfunction

  // expected result of one accepted item; advances the predicted state
  function automatic out_item_t step_result(input in_item_t item);
    out_item_t            res;
    logic [4:0]           move;
    logic [SENS_BITS-1:0] sens;
    logic [TIME_BITS-1:0] span;
    int unsigned          ratio;
    longint               speed;
    longint               sum;
    res.step_dir = DIR_NONE;
    if (item.cmd == CMD_READ) begin
      res.step_total = enc_total;
      res.pressed    = enc_pressed;
      enc_total      = '0;
      read_cmds++;
      return res;
    end
    pin_events++;
    if (cfg_switch)
      enc_pressed = ~item.switch_level;
    move      = half_step(enc_state, {~item.left_level, ~item.right_level});
    enc_state = move[2:0];
    if ((move & (TURN_CW | TURN_CCW)) != 5'd0) begin
      // zero window acts as one ms; elapsed clamped to 1..window
      sens = (cfg_sens == '0) ? SENS_BITS'(1) : cfg_sens;
      span = item.now_ms - enc_last_ms;
      if (span == '0)
        span = TIME_BITS'(1);
      if (span > TIME_BITS'(sens))
        span = TIME_BITS'(sens);
      ratio       = int'(sens) / int'(span);
      speed       = longint'(ratio * ratio);
      enc_last_ms = item.now_ms;
      if ((move & TURN_CW) != 5'd0) begin
        sum          = longint'(enc_total) + speed;
        res.step_dir = DIR_CW;
        cw_detents++;
      end else begin
        sum          = longint'(enc_total) - speed;
        res.step_dir = DIR_CCW;
        ccw_detents++;
      end
      if (sum > TOTAL_MAX) begin
        sum = TOTAL_MAX;
        clamped++;
      end else if (sum < TOTAL_MIN) begin
        sum = TOTAL_MIN;
        clamped++;
      end
      enc_total = sum[ACC_BITS-1:0];
    end
    res.step_total = enc_total;
    res.pressed    = enc_pressed;
    return res;
  endfunction

  // counts a failure, true while it is still worth printing
  function automatic bit count_failure();
    mismatches++;
    return mismatches <= 10;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // time step before a detent: zero, short, long, wrapping or backwards
  function automatic logic [TIME_BITS-1:0] detent_gap();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2, 3: return TIME_BITS'($urandom_range(1, 4));
      4, 5, 6, 7: return TIME_BITS'($urandom_range(1, 300));
      8: return TIME_BITS'($urandom);
      default: return -TIME_BITS'($urandom_range(1, 50));
    endcase
  endfunction

  function automatic void push_pin(input logic [1:0] act, input logic sw,
                                   input logic [TIME_BITS-1:0] ms);
    in_item_t item;
    item.cmd          = CMD_PIN;
    item.left_level   = ~act[1];
    item.right_level  = ~act[0];
    item.switch_level = sw;
    item.now_ms       = ms;
    pending_items.push_back(item);
    items_queued++;
  endfunction

  // read and clear; the other fields are don't-care and kept random
  function automatic void push_read();
    in_item_t item;
    item.cmd          = CMD_READ;
    item.left_level   = 1'($urandom);
    item.right_level  = 1'($urandom);
    item.switch_level = 1'($urandom);
    item.now_ms       = TIME_BITS'($urandom);
    pending_items.push_back(item);
    items_queued++;
  endfunction

  // one full detent; the third active pair decides the direction
  function automatic void push_detent(input logic [1:0] first, input logic [1:0] last,
                                      input logic sw, input logic [TIME_BITS-1:0] ms);
    push_pin(first, sw, ms);
    push_pin(ACT_BOTH, sw, ms);
    push_pin(last, sw, ms);
    push_pin(ACT_NONE, sw, ms);
  endfunction

  // mostly clean detents, with reads and stray pin levels mixed in
  function automatic void queue_traffic(input int count);
    int       target;
    int       pick;
    logic [1:0] first;
    logic [1:0] last;
    target = items_queued + count;
    while (items_queued < target) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 11) == 0)
        gen_sw = ~gen_sw;
      if (pick < 8) begin
        push_read();
      end else if (pick < 24) begin
        gen_ms = gen_ms + TIME_BITS'($urandom_range(0, 3));
        push_pin(2'($urandom), gen_sw,
                 ($urandom_range(0, 4) == 0) ? TIME_BITS'($urandom) : gen_ms);
      end else begin
        gen_ms = gen_ms + detent_gap();
        first  = $urandom_range(0, 1) ? ACT_RIGHT : ACT_LEFT;
        last   = $urandom_range(0, 1) ? ACT_RIGHT : ACT_LEFT;
        push_detent(first, last, gen_sw, gen_ms);
      end
    end
  endfunction

  // fastest possible turning in one direction, largest speed on every detent after the first
  function automatic void queue_spin(input logic clockwise, input logic [TIME_BITS-1:0] ms);
    int i;
    push_read();
    push_pin(ACT_NONE, 1'b1, ms);
    for (i = 0; i < SPIN_DETENTS; i++) begin
      push_pin(ACT_BOTH, 1'b1, ms);
      push_pin(clockwise ? ACT_RIGHT : ACT_LEFT, 1'b1, ms);
      push_pin(ACT_NONE, 1'b1, ms);
    end
    push_read();
  endfunction

  // register write followed by a read back of the stored bits
  task automatic write_reg(input logic idx, input logic [DATA_BITS-1:0] value);
    logic [DATA_BITS-1:0] mask;
    logic [DATA_BITS-1:0] seen;
    mask = (idx == REG_SENS) ? DATA_BITS'(8'hff) : DATA_BITS'(1);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_SENS)
      cfg_sens = value[SENS_BITS-1:0];
    else
      cfg_switch = value[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((seen & mask) !== (value & mask))
      if (count_failure())
        $display("register %0d read back %h, expected %h", idx, seen & mask, value & mask);
  endtask

  task automatic set_registers(input logic [SENS_BITS-1:0] sens, input logic sw);
    write_reg(REG_SENS, {24'($urandom), sens});
    write_reg(REG_SWITCH, {31'($urandom), sw});
    settings++;
  endtask

  // hold the sender until every queued item has come back
  task automatic wait_quiet();
    while (pending_items.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // driver: presents the oldest pending item, predicts it when taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(step_result(in_data));
        void'(pending_items.pop_front());
        gap_run = calm ? 0 : pick_gap();
      end
      if (in_valid && in_stall) begin
        // item held until taken
      end else if (gap_run != 0) begin
        gap_run = gap_run - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stalls in random runs
  always @(posedge clk) begin
    if (rst || calm)
      stall_run = 0;
    else if (stall_run != 0)
      stall_run = stall_run - 1;
    else if ($urandom_range(0, 3) == 0)
      stall_run = pick_gap();
    out_stall <= (stall_run != 0);
  end

  // monitor: each taken result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        if (count_failure())
          $display("unexpected result: total %0d pressed %0b dir %0d",
                   $signed(out_data.step_total), out_data.pressed, out_data.step_dir);
      end else begin
        want = expected_results.pop_front();
        if (out_data.step_total !== want.step_total || out_data.pressed !== want.pressed ||
            out_data.step_dir !== want.step_dir)
          if (count_failure())
            $display("result mismatch: expected total %0d pressed %0b dir %0d, got %0d %0b %0d",
                     $signed(want.step_total), want.pressed, want.step_dir,
                     $signed(out_data.step_total), out_data.pressed, out_data.step_dir);
      end
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("no progress for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, expected_results.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst    <= 1'b0;
    gen_ms = TIME_BITS'($urandom);

    // directed opening at reset settings: timestamp extremes, wrap,
    // time going backwards, both first halves, switch tracking, reads
    push_read();
    push_pin(ACT_NONE, 1'b0, 32'd0);
    push_detent(ACT_RIGHT, ACT_RIGHT, 1'b0, 32'd0);
    push_detent(ACT_LEFT, ACT_LEFT, 1'b1, 32'hffff_ffff);
    push_detent(ACT_LEFT, ACT_RIGHT, 1'b1, 32'd5);
    push_detent(ACT_RIGHT, ACT_LEFT, 1'b0, 32'd3);
    push_detent(ACT_RIGHT, ACT_RIGHT, 1'b1, 32'd19);
    push_pin(ACT_BOTH, 1'b1, 32'd20);
    push_pin(ACT_NONE, 1'b1, 32'd20);
    push_read();
    push_read();
    wait_quiet();

    // widest window, switch ignored; pause half way until drained
    set_registers(8'd255, 1'b0);
    queue_traffic(100);
    wait_quiet();
    queue_traffic(100);
    wait_quiet();

    // narrowest window
    set_registers(8'd1, 1'b1);
    queue_traffic(200);
    wait_quiet();

    // zero window behaves as one
    set_registers(8'd0, 1'b0);
    queue_traffic(150);
    wait_quiet();

    repeat (3) begin
      set_registers(SENS_BITS'($urandom_range(2, 254)), 1'($urandom));
      queue_traffic(200);
      wait_quiet();
    end

    // a stretch with no gaps and no stalls
    calm = 1'b1;
    set_registers(SENS_RESET, 1'b1);
    queue_traffic(150);
    wait_quiet();

    // short full speed spins both ways at the widest window
    set_registers(8'd255, 1'b1);
    queue_spin(1'b1, TIME_BITS'($urandom));
    queue_spin(1'b0, TIME_BITS'($urandom));
    wait_quiet();
    repeat (20) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
    $display("covered %0d pin events, %0d reads, %0d cw and %0d ccw detents",
             pin_events, read_cmds, cw_detents, ccw_detents);
    $display("%0d totals held at a limit over %0d register settings, %0d failures",
             clamped, settings, mismatches);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
